### hdl/gbpef_pkg.sv
// Shared constants, latencies and status codes for the GB pair energy/force core.
// No dependencies; imported by every module of the block but gbpef_delay.
package gbpef_pkg;

	localparam int INDEX_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	// quotient bits kept by the dividers; a larger quotient always saturates
	localparam int QUO_W = 48;

	// register stages of each unit, input register excluded
	localparam int LAT_EXP  = 81;          // 1 setup + 32 fraction + 42 series + 1 clamp + 5 squares
	localparam int LAT_ROOT = 34;          // 2 for S + 32 root bits
	localparam int LAT_DIV  = QUO_W + 1;
	localparam int FRONT    = 3;           // input, products, magnitudes
	localparam int CUBE_LAT = 3;
	localparam int STAGE_F  = FRONT + LAT_EXP + LAT_ROOT;
	localparam int PIPE_DEPTH = STAGE_F + CUBE_LAT + LAT_DIV;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ZERO_RADIUS = 2'd1,
		ST_SATURATED   = 2'd2
	} status_t;

endpackage

### hdl/gbpef_delay.sv
// Enabled shift line that aligns side data with the arithmetic units.
// Depends on nothing; used by the core top level.
module gbpef_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule

### hdl/gbpef_exp.sv
// Pipelined e = exp(-L^2/(4*RR)) in Q1.32: fraction divide, 14-term series, 5 squarings.
// Uses gbpef_pkg.
module gbpef_exp import gbpef_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] l2,
	input  logic [47:0] rr,
	output logic [32:0] e
);

	typedef struct packed {
		logic [54:0] den;
		logic [54:0] r;
		logic [31:0] fr;
		logic        ge;
	} dstep_t;

	typedef struct packed {
		logic [32:0] term;
		logic [35:0] sum;
		logic [31:0] fr;
		logic        ge;
	} tay_t;

	typedef struct packed {
		logic [31:0] p;
		logic [31:0] qe;
		logic [35:0] sum;
		logic [31:0] fr;
		logic        ge;
	} mid_t;

	dstep_t      dv_s  [32];
	tay_t        tay_s [15];
	mid_t        ta_s  [14];
	mid_t        tb_s  [14];
	logic [32:0] sq_s  [6];

	// setup: den = 128*RR, argument too large -> e = 0
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].den <= {rr, 7'd0};
			dv_s[0].ge  <= l2 >= {7'd0, rr, 7'd0};
			dv_s[0].r   <= l2[54:0];
			dv_s[0].fr  <= '0;
		end
	end

	// one fraction bit per stage
	for (genvar k = 0; k < 32; k++) begin : g_frac
		logic [55:0] t;
		logic        take;
		logic [54:0] rn;
		logic [31:0] fn;

		assign t    = {dv_s[k].r, 1'b0};
		assign take = t >= {1'b0, dv_s[k].den};
		assign rn   = take ? 55'(t - {1'b0, dv_s[k].den}) : t[54:0];
		assign fn   = {dv_s[k].fr[30:0], take};

		if (k < 31) begin : g_mid
			always_ff @(posedge clk) begin
				if (en) begin
					dv_s[k+1].den <= dv_s[k].den;
					dv_s[k+1].r   <= rn;
					dv_s[k+1].fr  <= fn;
					dv_s[k+1].ge  <= dv_s[k].ge;
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (en) begin
					tay_s[0].term <= 33'h1_0000_0000;
					tay_s[0].sum  <= 36'h1_0000_0000;
					tay_s[0].fr   <= fn;
					tay_s[0].ge   <= dv_s[k].ge;
				end
			end
		end
	end

	// series term n: multiply, reciprocal estimate, correction and accumulate
	for (genvar j = 0; j < 14; j++) begin : g_term
		localparam int          NTERM = j + 1;
		localparam logic [36:0] RECIP = 37'((64'd1 << 36) / NTERM);

		logic [64:0] prod_a;
		logic [68:0] prod_b;
		logic [31:0] rem_c;
		logic [31:0] q_c;

		assign prod_a = tay_s[j].term * {1'b0, tay_s[j].fr};
		assign prod_b = ta_s[j].p * RECIP;
		assign rem_c  = tb_s[j].p - 32'(tb_s[j].qe * 32'(NTERM));
		assign q_c    = (rem_c >= 32'(NTERM)) ? tb_s[j].qe + 32'd1 : tb_s[j].qe;

		always_ff @(posedge clk) begin
			if (en) begin
				ta_s[j].p   <= prod_a[63:32];
				ta_s[j].qe  <= '0;
				ta_s[j].sum <= tay_s[j].sum;
				ta_s[j].fr  <= tay_s[j].fr;
				ta_s[j].ge  <= tay_s[j].ge;

				tb_s[j].p   <= ta_s[j].p;
				tb_s[j].qe  <= prod_b[67:36];
				tb_s[j].sum <= ta_s[j].sum;
				tb_s[j].fr  <= ta_s[j].fr;
				tb_s[j].ge  <= ta_s[j].ge;

				tay_s[j+1].term <= {1'b0, q_c};
				if (NTERM % 2 == 1) begin
					tay_s[j+1].sum <= 36'($signed(tb_s[j].sum) - $signed({4'd0, q_c}));
				end else begin
					tay_s[j+1].sum <= 36'($signed(tb_s[j].sum) + $signed({4'd0, q_c}));
				end
				tay_s[j+1].fr <= tb_s[j].fr;
				tay_s[j+1].ge <= tb_s[j].ge;
			end
		end
	end

	// clamp to [0, 1]
	always_ff @(posedge clk) begin
		if (en) begin
			if (tay_s[14].ge || $signed(tay_s[14].sum) < 0) begin
				sq_s[0] <= '0;
			end else if ($signed(tay_s[14].sum) > $signed(36'h1_0000_0000)) begin
				sq_s[0] <= 33'h1_0000_0000;
			end else begin
				sq_s[0] <= tay_s[14].sum[32:0];
			end
		end
	end

	// raise to the 32nd power; one stays one
	for (genvar k = 0; k < 5; k++) begin : g_sq
		logic [63:0] pv;

		assign pv = sq_s[k][31:0] * sq_s[k][31:0];

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1] <= sq_s[k][32] ? sq_s[k] : {1'b0, pv[63:32]};
			end
		end
	end

	assign e = sq_s[5];

endmodule

### hdl/gbpef_root.sv
// Pipelined f = floor(sqrt(L^2 + floor(RR*e/2^32))), one root bit per stage.
// Uses gbpef_pkg.
module gbpef_root import gbpef_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] l2,
	input  logic [47:0] rr,
	input  logic [32:0] e,
	output logic [31:0] f
);

	logic [56:0] phi_s1;
	logic [56:0] plo_s1;
	logic [61:0] l2_s1;
	logic [80:0] prod;
	logic [63:0] rem_s  [33];
	logic [31:0] root_s [33];

	assign prod = (81'(phi_s1) << 24) + 81'(plo_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s1    <= rr[47:24] * e;
			plo_s1    <= rr[23:0] * e;
			l2_s1     <= l2;
			rem_s[0]  <= 64'(l2_s1) + 64'(prod[80:32]);
			root_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < 32; k++) begin : g_bit
		localparam int B = 31 - k;
		logic [63:0] trial;
		logic        take;

		assign trial = (64'(root_s[k]) << (B + 1)) | (64'd1 << (2 * B));
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
				root_s[k+1] <= take ? (root_s[k] | (32'd1 << B)) : root_s[k];
			end
		end
	end

	assign f = root_s[32];

endmodule

### hdl/gbpef_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// for quotients wider than QUO_W bits. Uses gbpef_pkg.
module gbpef_div import gbpef_pkg::*; #(
	parameter int NUM_W = 55,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic             ovf
);

	localparam int HI_W  = NUM_W - QUO_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] shq_s [QUO_W+1];
	logic             ovf_s [QUO_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= CMP_W'(num >> QUO_W) >= CMP_W'(den);
			rem_s[0] <= DEN_W'(num >> QUO_W);
			shq_s[0] <= num[QUO_W-1:0];
			den_s[0] <= den;
		end
	end

	// shq holds the numerator bits still to come, quotient bits fill from the bottom
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] t;
		logic           take;

		assign t    = {rem_s[k], shq_s[k][QUO_W-1]};
		assign take = t >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				shq_s[k+1] <= {shq_s[k][QUO_W-2:0], take};
				ovf_s[k+1] <= ovf_s[k];
			end
		end

		if (k < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= take ? DEN_W'(t - {1'b0, den_s[k]}) : t[DEN_W-1:0];
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign quo = shq_s[QUO_W];
	assign ovf = ovf_s[QUO_W];

endmodule

### hdl/gb_pair_energy_and_force_core.sv
// Generalized Born (Still) pair screening energy and force, fixed point.
// Uses gbpef_pkg, gbpef_delay, gbpef_exp, gbpef_root, gbpef_div.
//
// One atom pair per transaction, one pair per clock sustained while the
// output queue has room: a fully pipelined datapath of 170 register stages
// (exp series, square root and the 48-step dividers set the depth), pairs
// in order. The whole pipe advances together whenever the two-entry output
// queue has a free slot; with the consumer holding out_ready low the queue
// fills and in_ready drops, nothing is lost or repeated. Per pair it forms
// e = exp(-L^2/(4*Ra*Rb)), f = sqrt(L^2 + Ra*Rb*e), the energy -k*q/f and
// the force on atom two (p2-p1)*(-(k*q/2)*(4-e)/f^3); atom one takes the
// negated force, applied by the consumer. Magnitudes truncate toward zero,
// outputs saturate to signed 48 bits (status 2), a zero radius gives zero
// outputs with status 1. k is written through cfg_wr_en/cfg_wr_data; the
// user must do so only while the core is idle, which the core does not
// enforce; it resets to zero. No clearing pass after reset.
module gb_pair_energy_and_force_core import gbpef_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// config
	input  logic               cfg_wr_en,
	input  logic        [31:0] cfg_wr_data,
	// pair input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [15:0] first_atom_index,
	input  logic        [15:0] second_atom_index,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] second_z,
	input  logic        [23:0] radius_one,
	input  logic        [23:0] radius_two,
	input  logic signed [23:0] charge_product,
	input  logic        [30:0] separation_length,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [15:0] atom_one_out,
	output logic        [15:0] atom_two_out,
	output logic signed [47:0] energy_term,
	output logic signed [47:0] force_x,
	output logic signed [47:0] force_y,
	output logic signed [47:0] force_z,
	output logic         [1:0] status
);

	localparam int          SHIFT    = 33 - FRAC_BITS;
	localparam logic [15:0] IDX_MASK = (INDEX_BITS >= 16) ? 16'hFFFF
		: 16'((32'd1 << INDEX_BITS) - 32'd1);

	typedef struct packed {
		logic [15:0] idx_a;
		logic [15:0] idx_b;
		logic        zero;
		logic        kpos;
		logic        kneg;
		logic [2:0]  dneg;
	} side_t;

	typedef struct packed {
		logic [15:0] idx_a;
		logic [15:0] idx_b;
		logic [47:0] energy;
		logic [47:0] fx;
		logic [47:0] fy;
		logic [47:0] fz;
		status_t     st;
	} out_rec_t;

	typedef struct packed {
		logic        sat;
		logic [47:0] val;
	} sat_res_t;

	// clamp a quotient magnitude to the signed 48-bit range and apply the sign
	function automatic sat_res_t clamp_out(input logic [47:0] q, input logic ovf,
		input logic neg);
		sat_res_t    r;
		logic [47:0] lim;
		logic [47:0] mag;
		lim   = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		r.sat = ovf | (q > lim);
		mag   = r.sat ? lim : q;
		r.val = neg ? (48'd0 - mag) : mag;
		return r;
	endfunction

	// ---------------- config and flow control ----------------
	logic [31:0] k_q;
	logic [1:0]  cnt_q;
	logic        en;
	logic        vld_s [1:PIPE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cfg_wr_en) begin
			k_q <= cfg_wr_data;
		end
	end

	// whole pipe moves while the output queue has room
	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= PIPE_DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= PIPE_DEPTH; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// ---------------- front: capture, products, magnitudes ----------------
	logic [15:0]        ia_s1, ib_s1;
	logic signed [31:0] p1_s1 [3];
	logic signed [31:0] p2_s1 [3];
	logic [23:0]        ra_s1, rb_s1;
	logic signed [23:0] q_s1;
	logic [30:0]        len_s1;

	logic [15:0]        ia_s2, ib_s2;
	logic [29:0]        hh_s2;
	logic [30:0]        hl_s2;
	logic [31:0]        ll_s2;
	logic [47:0]        rr_s2;
	logic signed [55:0] kq_s2;
	logic signed [32:0] d_s2 [3];
	logic               zero_s2;

	logic [61:0]        l2_s3;
	logic [47:0]        rr_s3;
	logic [54:0]        kqm_s3;
	logic [98:0]        dm_s3;
	side_t              side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ia_s1    <= first_atom_index & IDX_MASK;
			ib_s1    <= second_atom_index & IDX_MASK;
			p1_s1[0] <= first_x;
			p1_s1[1] <= first_y;
			p1_s1[2] <= first_z;
			p2_s1[0] <= second_x;
			p2_s1[1] <= second_y;
			p2_s1[2] <= second_z;
			ra_s1    <= radius_one;
			rb_s1    <= radius_two;
			q_s1     <= charge_product;
			len_s1   <= separation_length;

			// L^2 in three partial products
			ia_s2   <= ia_s1;
			ib_s2   <= ib_s1;
			hh_s2   <= len_s1[30:16] * len_s1[30:16];
			hl_s2   <= len_s1[30:16] * len_s1[15:0];
			ll_s2   <= len_s1[15:0] * len_s1[15:0];
			rr_s2   <= ra_s1 * rb_s1;
			kq_s2   <= 56'($signed(k_q)) * 56'(q_s1);
			zero_s2 <= (ra_s1 == '0) || (rb_s1 == '0);
			for (int a = 0; a < 3; a++) begin
				d_s2[a] <= 33'(p2_s1[a]) - 33'(p1_s1[a]);
			end

			l2_s3  <= (62'(hh_s2) << 32) + (62'(hl_s2) << 17) + 62'(ll_s2);
			rr_s3  <= rr_s2;
			kqm_s3 <= kq_s2[55] ? 55'(-kq_s2) : 55'(kq_s2);
			for (int a = 0; a < 3; a++) begin
				dm_s3[a*33 +: 33] <= d_s2[a][32] ? 33'(-d_s2[a]) : 33'(d_s2[a]);
			end
			side_s3.idx_a <= ia_s2;
			side_s3.idx_b <= ib_s2;
			side_s3.zero  <= zero_s2;
			side_s3.kpos  <= (kq_s2 > 0);
			side_s3.kneg  <= kq_s2[55];
			side_s3.dneg  <= {d_s2[2][32], d_s2[1][32], d_s2[0][32]};
		end
	end

	// ---------------- exp and root ----------------
	logic [32:0] e_exp;
	logic [61:0] l2_d;
	logic [47:0] rr_d;
	logic [31:0] f_root;

	gbpef_exp u_exp (
		.clk (clk),
		.en  (en),
		.l2  (l2_s3),
		.rr  (rr_s3),
		.e   (e_exp)
	);

	gbpef_delay #(.WIDTH(110), .DEPTH(LAT_EXP)) u_dly_root (
		.clk  (clk),
		.en   (en),
		.din  ({l2_s3, rr_s3}),
		.dout ({l2_d, rr_d})
	);

	gbpef_root u_root (
		.clk (clk),
		.en  (en),
		.l2  (l2_d),
		.rr  (rr_d),
		.e   (e_exp),
		.f   (f_root)
	);

	// ---------------- force numerator, runs beside the root ----------------
	logic [32:0] e_d;
	logic [54:0] kqm_d;
	logic [98:0] dm_d;

	gbpef_delay #(.WIDTH(33), .DEPTH(LAT_ROOT - 1)) u_dly_e (
		.clk  (clk),
		.en   (en),
		.din  (e_exp),
		.dout (e_d)
	);

	gbpef_delay #(.WIDTH(154), .DEPTH(LAT_EXP + LAT_ROOT - 1)) u_dly_kd (
		.clk  (clk),
		.en   (en),
		.din  ({kqm_s3, dm_s3}),
		.dout ({kqm_d, dm_d})
	);

	logic [34:0]  w_s118, w_s119;
	logic [54:0]  kqm_s118, kqm_s119, kqm_s120, kqm_s121;
	logic [64:0]  alo_s118 [3];
	logic [55:0]  ahi_s118 [3];
	logic [87:0]  amag_s119 [3];
	logic [64:0]  pp0_s120 [3];
	logic [64:0]  pp1_s120 [3];
	logic [62:0]  pp2_s120 [3];
	logic [121:0] ns_s121 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			w_s118   <= 35'h4_0000_0000 - 35'(e_d);
			kqm_s118 <= kqm_d;
			w_s119   <= w_s118;
			kqm_s119 <= kqm_s118;
			kqm_s120 <= kqm_s119;
			kqm_s121 <= kqm_s120;
			for (int a = 0; a < 3; a++) begin
				alo_s118[a]  <= kqm_d[31:0] * dm_d[a*33 +: 33];
				ahi_s118[a]  <= kqm_d[54:32] * dm_d[a*33 +: 33];
				amag_s119[a] <= 88'(alo_s118[a]) + (88'(ahi_s118[a]) << 32);
				pp0_s120[a]  <= amag_s119[a][29:0] * w_s119;
				pp1_s120[a]  <= amag_s119[a][59:30] * w_s119;
				pp2_s120[a]  <= amag_s119[a][87:60] * w_s119;
				ns_s121[a]   <= (122'(pp0_s120[a]) + (122'(pp1_s120[a]) << 30)
					+ (122'(pp2_s120[a]) << 60)) >> SHIFT;
			end
		end
	end

	// ---------------- f^3 ----------------
	logic [63:0] f2_s119;
	logic [31:0] f_s119, f_s120, f_s121;
	logic [63:0] clo_s120, chi_s120;
	logic [95:0] f3_s121;

	always_ff @(posedge clk) begin
		if (en) begin
			f2_s119  <= f_root * f_root;
			f_s119   <= f_root;
			clo_s120 <= f2_s119[31:0] * f_s119;
			chi_s120 <= f2_s119[63:32] * f_s119;
			f_s120   <= f_s119;
			f3_s121  <= 96'(clo_s120) + (96'(chi_s120) << 32);
			f_s121   <= f_s120;
		end
	end

	// ---------------- dividers ----------------
	logic [QUO_W-1:0] qe_d;
	logic             ovfe_d;
	logic [QUO_W-1:0] qf_d [3];
	logic             ovff_d [3];

	gbpef_div #(.NUM_W(55), .DEN_W(32)) u_div_energy (
		.clk (clk),
		.en  (en),
		.num (kqm_s121),
		.den (f_s121),
		.quo (qe_d),
		.ovf (ovfe_d)
	);

	for (genvar a = 0; a < 3; a++) begin : g_axis
		gbpef_div #(.NUM_W(122), .DEN_W(96)) u_div_force (
			.clk (clk),
			.en  (en),
			.num (ns_s121[a]),
			.den (f3_s121),
			.quo (qf_d[a]),
			.ovf (ovff_d[a])
		);
	end

	side_t side_d;

	gbpef_delay #(.WIDTH($bits(side_t)), .DEPTH(PIPE_DEPTH - FRONT)) u_dly_side (
		.clk  (clk),
		.en   (en),
		.din  (side_s3),
		.dout (side_d)
	);

	// ---------------- saturation, status ----------------
	sat_res_t sr_e;
	sat_res_t sr_f [3];
	out_rec_t rec;

	always_comb begin
		sr_e = clamp_out(qe_d, ovfe_d, side_d.kpos);
		for (int a = 0; a < 3; a++) begin
			sr_f[a] = clamp_out(qf_d[a], ovff_d[a], side_d.kneg == side_d.dneg[a]);
		end
		rec.idx_a = side_d.idx_a;
		rec.idx_b = side_d.idx_b;
		if (side_d.zero) begin
			rec.energy = '0;
			rec.fx     = '0;
			rec.fy     = '0;
			rec.fz     = '0;
			rec.st     = ST_ZERO_RADIUS;
		end else begin
			rec.energy = sr_e.val;
			rec.fx     = sr_f[0].val;
			rec.fy     = sr_f[1].val;
			rec.fz     = sr_f[2].val;
			rec.st     = (sr_e.sat | sr_f[0].sat | sr_f[1].sat | sr_f[2].sat)
				? ST_SATURATED : ST_OK;
		end
	end

	// ---------------- two-entry output queue ----------------
	out_rec_t q0_q, q1_q;
	logic     push, pop;

	assign push = en & vld_s[PIPE_DEPTH];
	assign pop  = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push) q0_q <= rec;
			end
			2'd1: begin
				if (push && pop) q0_q <= rec;
				else if (push) q1_q <= rec;
			end
			default: begin
				if (pop) q0_q <= q1_q;
			end
		endcase
	end

	assign out_valid    = (cnt_q != 2'd0);
	assign atom_one_out = q0_q.idx_a;
	assign atom_two_out = q0_q.idx_b;
	assign energy_term  = q0_q.energy;
	assign force_x      = q0_q.fx;
	assign force_y      = q0_q.fy;
	assign force_z      = q0_q.fz;
	assign status       = q0_q.st;

endmodule

### tb/gbpef_checker.sv
// Scoreboard for gb_pair_energy_and_force_core: watches the pair, result and
// config ports, predicts each result and compares it. Depends on gbpef_pkg.
`timescale 1ns / 1ps
module gbpef_checker import gbpef_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic        [31:0] cfg_wr_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic        [15:0] first_atom_index,
	input  logic        [15:0] second_atom_index,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] second_z,
	input  logic        [23:0] radius_one,
	input  logic        [23:0] radius_two,
	input  logic signed [23:0] charge_product,
	input  logic        [30:0] separation_length,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic        [15:0] atom_one_out,
	input  logic        [15:0] atom_two_out,
	input  logic signed [47:0] energy_term,
	input  logic signed [47:0] force_x,
	input  logic signed [47:0] force_y,
	input  logic signed [47:0] force_z,
	input  logic         [1:0] status,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic [15:0] atom_one;
		logic [15:0] atom_two;
		logic [47:0] energy;
		logic [47:0] fx;
		logic [47:0] fy;
		logic [47:0] fz;
		status_t     st;
	} pair_result_t;

	pair_result_t expected_results[$];
	logic signed [31:0] k_reg;

	// e = exp(-L^2/(4*RR)) as Q1.32: series on x/32, then squared five times
	function automatic logic [63:0] screening_exp(input logic [63:0] l2, input logic [63:0] rr);
		logic [127:0] den, fr;
		logic [63:0] term, v;
		logic signed [63:0] acc;
		den = {64'd0, rr} << 7;
		if ({64'd0, l2} >= den)
			return 64'd0;
		fr = ({64'd0, l2} << 32) / den;
		term = 64'h1_0000_0000;
		acc = 64'sh1_0000_0000;
		for (int i = 1; i <= 14; i++) begin
			term = ((term * fr[63:0]) >> 32) / i;
			if (i % 2 == 1)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		if (acc < 0)
			acc = 0;
		v = acc;
		if (v > 64'h1_0000_0000)
			v = 64'h1_0000_0000;
		for (int i = 0; i < 5; i++)
			if (v < 64'h1_0000_0000)
				v = (v * v) >> 32;
		return v;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// {saturated, 48-bit value}
	function automatic logic [48:0] clamp48(input logic [127:0] mag, input bit neg);
		logic [127:0] lim;
		logic [47:0] val;
		bit over;
		lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
		over = mag > lim;
		if (over)
			mag = lim;
		val = neg ? -mag[47:0] : mag[47:0];
		return {over, val};
	endfunction

	function automatic pair_result_t predict_pair(
		input logic [15:0] i1, input logic [15:0] i2,
		input logic signed [31:0] p1 [3], input logic signed [31:0] p2 [3],
		input logic [23:0] ra, input logic [23:0] rb,
		input logic signed [23:0] q, input logic [30:0] len);
		pair_result_t r;
		logic signed [63:0] kq, d;
		logic [63:0] kqm, dm, rr, l2, e, f, w;
		logic [127:0] prod;
		logic [48:0] c;
		bit sat;
		r = '0;
		r.atom_one = i1;
		r.atom_two = i2;
		if (ra == 0 || rb == 0) begin
			r.st = ST_ZERO_RADIUS;
			return r;
		end
		sat = 0;
		kq = 64'(k_reg) * 64'(q);
		kqm = kq < 0 ? -kq : kq;
		rr = ra * rb;
		l2 = len * len;
		e = screening_exp(l2, rr);
		prod = ({64'd0, rr} * {64'd0, e}) >> 32;
		f = floor_sqrt(l2 + prod[63:0]);
		if (f == 0)
			f = 1;
		c = clamp48({64'd0, kqm / f}, kq > 0);
		sat |= c[48];
		r.energy = c[47:0];
		w = (64'd4 << 32) - e;
		for (int ax = 0; ax < 3; ax++) begin
			d = 64'(p2[ax]) - 64'(p1[ax]);
			dm = d < 0 ? -d : d;
			prod = {64'd0, kqm} * {64'd0, dm} * {64'd0, w};
			prod = prod / f;
			prod = prod / f;
			prod = prod / f;
			prod = prod >> (33 - FRAC_BITS_DEF);
			c = clamp48(prod, (kq < 0) == (d < 0));
			sat |= c[48];
			case (ax)
				0: r.fx = c[47:0];
				1: r.fy = c[47:0];
				default: r.fz = c[47:0];
			endcase
		end
		r.st = sat ? ST_SATURATED : ST_OK;
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		pair_result_t want;
		logic signed [31:0] p1 [3];
		logic signed [31:0] p2 [3];
		if (!arst_n) begin
			k_reg <= '0;
			fail_count <= 0;
			expected_results.delete();
		end else begin
			if (cfg_wr_en)
				k_reg <= cfg_wr_data;
			if (in_valid && in_ready) begin
				p1 = '{first_x, first_y, first_z};
				p2 = '{second_x, second_y, second_z};
				expected_results.push_back(predict_pair(first_atom_index, second_atom_index,
					p1, p2, radius_one, radius_two, charge_product, separation_length));
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transaction, atoms %0d/%0d",
							atom_one_out, atom_two_out);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.atom_one != atom_one_out || want.atom_two != atom_two_out ||
							want.energy != energy_term || want.fx != force_x ||
							want.fy != force_y || want.fz != force_z || want.st != status) begin
						if (fail_count < 10) begin
							$display("mismatch atoms exp %0d/%0d got %0d/%0d", want.atom_one,
								want.atom_two, atom_one_out, atom_two_out);
							$display("  energy exp %h got %h status exp %0d got %0d",
								want.energy, energy_term, want.st, status);
							$display("  force exp %h %h %h got %h %h %h", want.fx, want.fy,
								want.fz, force_x, force_y, force_z);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### tb/tb_gb_pair_energy_and_force_core.sv
// Top of the GB pair energy/force testbench: clock, reset, pair stimulus, result-side
// backpressure and the verdict. Depends on gbpef_pkg, gbpef_checker and the core.
`timescale 1ns / 1ps
module tb_gb_pair_energy_and_force_core import gbpef_pkg::*;;

	localparam int IDLE_LIMIT = 6000;   // cycles with no transaction on either side
	localparam int HOLD_CYCLES = 500;   // long consumer hold-off

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_wr_en = 0;
	logic        [31:0] cfg_wr_data = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic        [15:0] first_atom_index = '0;
	logic        [15:0] second_atom_index = '0;
	logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
	logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
	logic        [23:0] radius_one = '0, radius_two = '0;
	logic signed [23:0] charge_product = '0;
	logic        [30:0] separation_length = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic        [15:0] atom_one_out, atom_two_out;
	logic signed [47:0] energy_term, force_x, force_y, force_z;
	logic         [1:0] status;

	int  fail_count, pending, idle_cycles;
	bit  hold_request = 0;
	bit  no_gaps = 0;

	always #10 clk = ~clk;

	gb_pair_energy_and_force_core uut (.*);

	gbpef_checker u_checker (.*);

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("tb_gb_pair_energy_and_force_core: errors");
			$finish;
		end
	end

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (no_gaps || r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Consumer: random stalls; one long hold-off when requested
	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 0;
			end
			g = pick_gap();
			if (g > 0) begin
				out_ready <= 0;
				repeat (g - 1) @(posedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	// Present one pair transaction and wait until it is taken; valid stays high
	task automatic send_pair(input logic [15:0] i1, input logic [15:0] i2,
		input logic [31:0] x1, input logic [31:0] y1, input logic [31:0] z1,
		input logic [31:0] x2, input logic [31:0] y2, input logic [31:0] z2,
		input logic [23:0] ra, input logic [23:0] rb, input logic [23:0] q,
		input logic [30:0] len);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		first_atom_index <= i1;
		second_atom_index <= i2;
		first_x <= x1; first_y <= y1; first_z <= z1;
		second_x <= x2; second_y <= y2; second_z <= z2;
		radius_one <= ra; radius_two <= rb;
		charge_product <= q;
		separation_length <= len;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [31:0] near_coord();
		return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;   // +-64.0
	endfunction

	// Mostly physical pairs, some raw noise, a few zero radii
	task automatic random_pair();
		int sel;
		logic [23:0] ra, rb;
		sel = $urandom_range(0, 99);
		if (sel < 78) begin
			send_pair(16'($urandom), 16'($urandom), near_coord(), near_coord(), near_coord(),
				near_coord(), near_coord(), near_coord(),
				24'($urandom_range(24'h0_8000, 24'h4_0000)),
				24'($urandom_range(24'h0_8000, 24'h4_0000)),
				24'($urandom_range(0, 24'h08_0000) - 24'h04_0000),
				31'($urandom_range(0, 31'h1E_0000)));
		end else if (sel < 95) begin
			ra = 24'($urandom);
			rb = 24'($urandom);
			send_pair(16'($urandom), 16'($urandom), $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, ra == 0 ? 24'd1 : ra, rb == 0 ? 24'd1 : rb,
				24'($urandom), 31'($urandom));
		end else begin
			ra = $urandom_range(0, 1) ? 24'd0 : 24'h1_8000;
			rb = ra != 0 ? 24'd0 : 24'($urandom);
			send_pair(16'($urandom), 16'($urandom), near_coord(), near_coord(), near_coord(),
				near_coord(), near_coord(), near_coord(), ra, rb, 24'($urandom),
				31'($urandom));
		end
	endtask

	// Edge cases: field extremes, zero radii, zero distance, e near 1 and e = 0
	task automatic directed_pairs();
		send_pair(16'h0000, 16'hFFFF, 0, 0, 0, 32'h0001_0000, 0, 0,
			24'h1_8000, 24'h1_8000, 24'h01_0000, 31'h1_0000);
		send_pair(16'hFFFF, 16'h0000, 0, 0, 0, 0, 0, 0, 24'h1_0000, 24'h1_0000, 24'h01_0000,
			31'd0);
		send_pair(16'd1, 16'd2, 0, 0, 0, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000,
			24'h0, 24'h1_0000, 24'h01_0000, 31'h2_0000);
		send_pair(16'd3, 16'd4, 0, 0, 0, 32'h0002_0000, 0, 0, 24'h1_0000, 24'h0, 24'h01_0000,
			31'h2_0000);
		send_pair(16'd5, 16'd6, 0, 0, 0, 32'h0002_0000, 0, 0, 24'h0, 24'h0, 24'h7F_FFFF,
			31'h2_0000);
		send_pair(16'd7, 16'd8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			24'h1, 24'h1, 24'h7F_FFFF, 31'h1);
		send_pair(16'd9, 16'd10, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			24'hFF_FFFF, 24'hFF_FFFF, 24'h80_0000, 31'h7FFF_FFFF);
		send_pair(16'd11, 16'd12, 0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0,
			24'hFF_FFFF, 24'hFF_FFFF, 24'h80_0000, 31'd0);
		send_pair(16'd13, 16'd14, 0, 0, 0, 32'h0064_0000, 0, 0,
			24'h1_0000, 24'h1_0000, 24'h01_0000, 31'h64_0000);
		send_pair(16'd15, 16'd16, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0,
			24'h2_0000, 24'h1_0000, 24'hFF_0000, 31'h0_8000);
		send_pair(16'd17, 16'd18, 0, 32'h0005_0000, 0, 0, 0, 0,
			24'h1, 24'hFF_FFFF, 24'h00_0001, 31'h7FFF_FFFF);
		send_pair(16'd19, 16'd20, 0, 0, 32'hFFF0_0000, 0, 0, 32'h0010_0000,
			24'h1_8000, 24'h2_8000, 24'h80_0000, 31'h0020_0000);
	endtask

	// Let the pipe drain, then write k while idle
	task automatic set_constant(input logic [31:0] k);
		in_valid <= 0;
		do @(posedge clk); while (pending != 0);
		cfg_wr_en <= 1;
		cfg_wr_data <= k;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	initial begin
		logic [31:0] settings [6];
		settings = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'hFFFF_0000, 32'h0000_0000};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset value of k: every energy and force is zero
		repeat (40) random_pair();

		foreach (settings[s]) begin
			set_constant(s == 5 ? $urandom : settings[s]);
			if (s < 3)
				directed_pairs();
			if (s == 1) begin
				// consumer stalls long while the producer keeps pushing
				hold_request = 1;
				no_gaps = 1;
				repeat (80) random_pair();
				no_gaps = 0;
			end
			repeat (100) random_pair();
		end

		in_valid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("tb_gb_pair_energy_and_force_core: clean");
		else
			$display("tb_gb_pair_energy_and_force_core: errors");
		$finish;
	end

endmodule
